@@ hw/rtl/gthf_pkg.sv @@
// Shared types and constants of the grayscale top-hat filter.
package gthf_pkg;

    localparam int W_W    = 11;
    localparam int H_W    = 13;
    localparam int WIN_W  = 5;
    localparam int HALF_W = 4;
    localparam int PIX_W  = 8;
    localparam int CNT_W  = 24;
    localparam int IDX_W  = 2;
    localparam int DATA_W = 13;

    localparam logic [IDX_W-1:0] REG_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_HEIGHT = 2'd1;
    localparam logic [IDX_W-1:0] REG_WINDOW = 2'd2;

    localparam int RST_WIDTH  = 640;
    localparam int RST_HEIGHT = 480;
    localparam int RST_WINDOW = 30;

    typedef struct packed {
        logic              wr_pix;
        logic [PIX_W-1:0]  pixel;
        logic [CNT_W-1:0]  t_pos;
        logic              do_erode;
        logic [CNT_W-1:0]  e_pos;
        logic [H_W-1:0]    e_row;
        logic [W_W-1:0]    e_col;
        logic              do_result;
        logic [CNT_W-1:0]  p_pos;
        logic [H_W-1:0]    p_row;
        logic [W_W-1:0]    p_col;
        logic              last;
        logic [W_W-1:0]    w;
        logic [H_W-1:0]    h;
        logic [HALF_W-1:0] half;
        logic [CNT_W-1:0]  lag;
    } cmd_t;

endpackage

@@ hw/rtl/gthf_front.sv @@
// Front end: configuration registers, frame counters and request classification.
module gthf_front
    import gthf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_HALF   = 15
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_index,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              push,
    input  logic              command,
    input  logic [PIX_W-1:0]  pixel,
    input  logic              q_full,
    output logic              q_push,
    output cmd_t              q_cmd
);

    localparam int RW_I    = (RST_WIDTH > MAX_WIDTH) ? MAX_WIDTH : RST_WIDTH;
    localparam int RH_I    = (RST_HEIGHT > MAX_HEIGHT) ? MAX_HEIGHT : RST_HEIGHT;
    localparam int RHALF_I = ((RST_WINDOW / 2) > MAX_HALF) ? MAX_HALF : (RST_WINDOW / 2);

    logic [W_W-1:0]    width_reg;
    logic [H_W-1:0]    height_reg;
    logic [WIN_W-1:0]  window_reg;
    logic [W_W-1:0]    gw_reg;
    logic [H_W-1:0]    gh_reg;
    logic [HALF_W-1:0] ghalf_reg;
    logic [CNT_W-1:0]  total_reg;
    logic [CNT_W-1:0]  lag_reg;
    logic [CNT_W-1:0]  t_reg, t_next;
    logic [CNT_W-1:0]  e_reg, e_next;
    logic [CNT_W-1:0]  p_reg, p_next;
    logic [H_W-1:0]    er_reg, er_next, pr_reg, pr_next;
    logic [W_W-1:0]    ec_reg, ec_next, pc_reg, pc_next;

    logic [W_W-1:0]    cw, fw;
    logic [H_W-1:0]    ch, fh;
    logic [HALF_W-1:0] chalf, fhalf;
    logic [CNT_W-1:0]  ctotal, clag, ftotal, flag;
    logic [CNT_W-1:0]  lag2;
    logic              geo_new;
    logic              t_in, item_ok, do_e, do_p, is_last, counted;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= W_W'(RST_WIDTH);
            height_reg <= H_W'(RST_HEIGHT);
            window_reg <= WIN_W'(RST_WINDOW);
        end
        else if (wr_en)
        begin
            unique case (wr_index)
                REG_WIDTH:  width_reg  <= wr_data[W_W-1:0];
                REG_HEIGHT: height_reg <= wr_data[H_W-1:0];
                REG_WINDOW: window_reg <= wr_data[WIN_W-1:0];
                default:    ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg == '0)
            cw = W_W'(1);
        else if (int'(width_reg) > MAX_WIDTH)
            cw = W_W'(MAX_WIDTH);
        else
            cw = width_reg;
        if (height_reg == '0)
            ch = H_W'(1);
        else if (int'(height_reg) > MAX_HEIGHT)
            ch = H_W'(MAX_HEIGHT);
        else
            ch = height_reg;
        if (int'(window_reg[WIN_W-1:1]) > MAX_HALF)
            chalf = HALF_W'(MAX_HALF);
        else
            chalf = window_reg[WIN_W-1:1];
    end

    assign ctotal = {{(CNT_W-W_W){1'b0}}, cw} * {{(CNT_W-H_W){1'b0}}, ch};
    assign clag   = {{(CNT_W-HALF_W){1'b0}}, chalf}
                  * ({{(CNT_W-W_W){1'b0}}, cw} + CNT_W'(1));

    // The first request of a frame sees the registers directly; later ones the latched copy.
    assign geo_new = (t_reg == '0);
    assign fw      = geo_new ? cw : gw_reg;
    assign fh      = geo_new ? ch : gh_reg;
    assign fhalf   = geo_new ? chalf : ghalf_reg;
    assign ftotal  = geo_new ? ctotal : total_reg;
    assign flag    = geo_new ? clag : lag_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gw_reg    <= W_W'(RW_I);
            gh_reg    <= H_W'(RH_I);
            ghalf_reg <= HALF_W'(RHALF_I);
            total_reg <= CNT_W'(RW_I * RH_I);
            lag_reg   <= CNT_W'(RHALF_I * (RW_I + 1));
        end
        else if (geo_new)
        begin
            gw_reg    <= cw;
            gh_reg    <= ch;
            ghalf_reg <= chalf;
            total_reg <= ctotal;
            lag_reg   <= clag;
        end
    end

    assign lag2    = {flag[CNT_W-2:0], 1'b0};
    assign t_in    = t_reg < ftotal;
    assign item_ok = t_in ? !command : command;
    assign do_e    = (t_reg >= flag) && (e_reg < ftotal);
    assign do_p    = (t_reg >= lag2) && (p_reg < ftotal);
    assign is_last = do_p && (p_reg == ftotal - CNT_W'(1));
    assign counted = push && !q_full && item_ok;
    assign q_push  = counted;

    always_comb
    begin
        q_cmd.wr_pix    = t_in;
        q_cmd.pixel     = pixel;
        q_cmd.t_pos     = t_reg;
        q_cmd.do_erode  = do_e;
        q_cmd.e_pos     = e_reg;
        q_cmd.e_row     = er_reg;
        q_cmd.e_col     = ec_reg;
        q_cmd.do_result = do_p;
        q_cmd.p_pos     = p_reg;
        q_cmd.p_row     = pr_reg;
        q_cmd.p_col     = pc_reg;
        q_cmd.last      = is_last;
        q_cmd.w         = fw;
        q_cmd.h         = fh;
        q_cmd.half      = fhalf;
        q_cmd.lag       = flag;
    end

    always_comb
    begin
        t_next  = t_reg;
        e_next  = e_reg;
        p_next  = p_reg;
        er_next = er_reg;
        ec_next = ec_reg;
        pr_next = pr_reg;
        pc_next = pc_reg;
        if (counted)
        begin
            if (is_last)
            begin
                t_next  = '0;
                e_next  = '0;
                p_next  = '0;
                er_next = '0;
                ec_next = '0;
                pr_next = '0;
                pc_next = '0;
            end
            else
            begin
                t_next = t_reg + CNT_W'(1);
                if (do_e)
                begin
                    e_next = e_reg + CNT_W'(1);
                    if (ec_reg == fw - W_W'(1))
                    begin
                        ec_next = '0;
                        er_next = er_reg + H_W'(1);
                    end
                    else
                        ec_next = ec_reg + W_W'(1);
                end
                if (do_p)
                begin
                    p_next = p_reg + CNT_W'(1);
                    if (pc_reg == fw - W_W'(1))
                    begin
                        pc_next = '0;
                        pr_next = pr_reg + H_W'(1);
                    end
                    else
                        pc_next = pc_reg + W_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            t_reg  <= '0;
            e_reg  <= '0;
            p_reg  <= '0;
            er_reg <= '0;
            ec_reg <= '0;
            pr_reg <= '0;
            pc_reg <= '0;
        end
        else
        begin
            t_reg  <= t_next;
            e_reg  <= e_next;
            p_reg  <= p_next;
            er_reg <= er_next;
            ec_reg <= ec_next;
            pr_reg <= pr_next;
            pc_reg <= pc_next;
        end
    end

endmodule

@@ hw/rtl/gthf_cmdq.sv @@
// Two-entry request queue between the front end and the window engine.
module gthf_cmdq
    import gthf_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t din,
    output logic full,
    input  logic pop,
    output cmd_t dout,
    output logic empty
);

    cmd_t       mem_reg [2];
    logic       wptr_reg, rptr_reg;
    logic [1:0] cnt_reg;
    logic       do_push, do_pop;

    assign full    = cnt_reg == 2'd2;
    assign empty   = cnt_reg == 2'd0;
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign dout    = mem_reg[rptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wptr_reg] <= din;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wptr_reg <= 1'b0;
            rptr_reg <= 1'b0;
            cnt_reg  <= 2'd0;
        end
        else
        begin
            if (do_push)
                wptr_reg <= !wptr_reg;
            if (do_pop)
                rptr_reg <= !rptr_reg;
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + 2'd1;
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - 2'd1;
        end
    end

endmodule

@@ hw/rtl/gthf_back.sv @@
// Window engine: line stores, erosion and dilation sweeps and the result register.
module gthf_back
    import gthf_pkg::*;
#(
    parameter int MAX_WIDTH = 1024,
    parameter int MAX_HALF  = 15
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    output logic             q_pop,
    input  cmd_t             q_cmd,
    input  logic             pop,
    output logic             empty,
    output logic [PIX_W-1:0] tophat,
    output logic             last
);

    // The stores are addressed by raster position modulo their power-of-two depth.
    localparam int AW    = $clog2((2 * MAX_HALF + 1) * (MAX_WIDTH + 1));
    localparam int DEPTH = 1 << AW;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_WPIX   = 4'd1;
    localparam logic [3:0] S_ELOOP  = 4'd2;
    localparam logic [3:0] S_EDRAIN = 4'd3;
    localparam logic [3:0] S_DLOOP  = 4'd4;
    localparam logic [3:0] S_DDRAIN = 4'd5;
    localparam logic [3:0] S_ORIG   = 4'd6;
    localparam logic [3:0] S_OWAIT  = 4'd7;

    logic [PIX_W-1:0] in_mem_reg [DEPTH];
    logic [PIX_W-1:0] er_mem_reg [DEPTH];
    logic [PIX_W-1:0] in_rd_reg, er_rd_reg;

    logic [3:0]        state_reg, state_next;
    cmd_t              cur_reg, cur_next;
    logic [HALF_W:0]   dr_reg, dr_next, dc_reg, dc_next;
    logic [AW-1:0]     wa_reg, wa_next;
    logic [PIX_W-1:0]  acc_reg, acc_next;
    logic              pend_reg, pend_next;
    logic [PIX_W-1:0]  opened_reg, opened_next;
    logic              out_vld_reg;
    logic [PIX_W-1:0]  tophat_reg;
    logic              last_reg;

    logic [HALF_W:0]       twoh;
    logic [H_W-1:0]        cr;
    logic [W_W-1:0]        ccen;
    logic signed [H_W+1:0] rr;
    logic signed [W_W+1:0] cc;
    logic                  win_in, last_it, slot_free, out_load;
    logic [AW-1:0]         t_addr, e_addr, p_addr, lag_a, in_raddr;
    logic [PIX_W-1:0]      e_final, d_final, diff;

    assign twoh = {cur_reg.half, 1'b0};
    assign cr   = (state_reg == S_ELOOP) ? cur_reg.e_row : cur_reg.p_row;
    assign ccen = (state_reg == S_ELOOP) ? cur_reg.e_col : cur_reg.p_col;
    assign rr   = $signed({2'b00, cr})
                + $signed({{(H_W+1-HALF_W){1'b0}}, dr_reg})
                - $signed({{(H_W+2-HALF_W){1'b0}}, cur_reg.half});
    assign cc   = $signed({2'b00, ccen})
                + $signed({{(W_W+1-HALF_W){1'b0}}, dc_reg})
                - $signed({{(W_W+2-HALF_W){1'b0}}, cur_reg.half});
    assign win_in = !rr[H_W+1] && (rr < $signed({2'b00, cur_reg.h}))
                 && !cc[W_W+1] && (cc < $signed({2'b00, cur_reg.w}));
    assign last_it = (dr_reg == twoh) && (dc_reg == twoh);

    assign t_addr   = cur_reg.t_pos[AW-1:0];
    assign e_addr   = cur_reg.e_pos[AW-1:0];
    assign p_addr   = cur_reg.p_pos[AW-1:0];
    assign lag_a    = cur_reg.lag[AW-1:0];
    assign in_raddr = (state_reg == S_ELOOP) ? wa_reg : p_addr;

    assign e_final = (pend_reg && (in_rd_reg < acc_reg)) ? in_rd_reg : acc_reg;
    assign d_final = (pend_reg && (er_rd_reg > acc_reg)) ? er_rd_reg : acc_reg;
    assign diff    = (in_rd_reg > opened_reg) ? (in_rd_reg - opened_reg) : '0;

    assign slot_free = !out_vld_reg || pop;
    assign out_load  = (state_reg == S_OWAIT) && slot_free;
    assign q_pop     = (state_reg == S_IDLE) && !q_empty;

    always_ff @(posedge clk)
    begin
        if ((state_reg == S_WPIX) && cur_reg.wr_pix)
            in_mem_reg[t_addr] <= cur_reg.pixel;
        in_rd_reg <= in_mem_reg[in_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_EDRAIN)
            er_mem_reg[e_addr] <= e_final;
        er_rd_reg <= er_mem_reg[wa_reg];
    end

    always_comb
    begin
        state_next  = state_reg;
        cur_next    = cur_reg;
        dr_next     = dr_reg;
        dc_next     = dc_reg;
        wa_next     = wa_reg;
        acc_next    = acc_reg;
        pend_next   = pend_reg;
        opened_next = opened_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    cur_next   = q_cmd;
                    state_next = S_WPIX;
                end
            end
            S_WPIX:
            begin
                dr_next   = '0;
                dc_next   = '0;
                pend_next = 1'b0;
                if (cur_reg.do_erode)
                begin
                    acc_next   = '1;
                    wa_next    = e_addr - lag_a;
                    state_next = S_ELOOP;
                end
                else if (cur_reg.do_result)
                begin
                    acc_next   = '0;
                    wa_next    = p_addr - lag_a;
                    state_next = S_DLOOP;
                end
                else
                    state_next = S_IDLE;
            end
            S_ELOOP, S_DLOOP:
            begin
                acc_next  = (state_reg == S_ELOOP) ? e_final : d_final;
                pend_next = win_in;
                if (dc_reg == twoh)
                begin
                    dc_next = '0;
                    dr_next = dr_reg + 1'b1;
                    wa_next = wa_reg + AW'(cur_reg.w) - AW'(twoh);
                end
                else
                begin
                    dc_next = dc_reg + 1'b1;
                    wa_next = wa_reg + AW'(1);
                end
                if (last_it)
                    state_next = (state_reg == S_ELOOP) ? S_EDRAIN : S_DDRAIN;
            end
            S_EDRAIN:
            begin
                dr_next   = '0;
                dc_next   = '0;
                pend_next = 1'b0;
                acc_next  = '0;
                wa_next   = p_addr - lag_a;
                state_next = cur_reg.do_result ? S_DLOOP : S_IDLE;
            end
            S_DDRAIN:
            begin
                opened_next = d_final;
                state_next  = S_ORIG;
            end
            S_ORIG:
                state_next = S_OWAIT;
            S_OWAIT:
            begin
                if (slot_free)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            out_vld_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (out_load)
                out_vld_reg <= 1'b1;
            else if (pop)
                out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg    <= cur_next;
        dr_reg     <= dr_next;
        dc_reg     <= dc_next;
        wa_reg     <= wa_next;
        acc_reg    <= acc_next;
        pend_reg   <= pend_next;
        opened_reg <= opened_next;
        if (out_load)
        begin
            tophat_reg <= diff;
            last_reg   <= cur_reg.last;
        end
    end

    assign empty  = !out_vld_reg;
    assign tophat = tophat_reg;
    assign last   = last_reg;

    a_row_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ELOOP || state_reg == S_DLOOP) |-> (dr_reg <= twoh))
        else $error("window row offset beyond the window");

    a_col_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ELOOP || state_reg == S_DLOOP) |-> (dc_reg <= twoh))
        else $error("window column offset beyond the window");

    a_erode_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EDRAIN) |-> cur_reg.do_erode)
        else $error("eroded store written for a request without erosion");

    a_result_req: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OWAIT) |-> cur_reg.do_result)
        else $error("result produced for a request without one");

endmodule

@@ hw/rtl/grayscale_top_hat_filter.sv @@
// Top level of the streaming white top-hat filter.
// Each accepted request writes its pixel if it carries one, then runs an erosion sweep and a
// dilation sweep over the (2h+1)x(2h+1) window when they are due, h being the window half-size.
// Both sweeps read one line-store entry per cycle.
// The result for raster position p appears on request p + 2h(width+1).
// Reset clears the counters and queues at once; the line stores need no clearing pass.
module grayscale_top_hat_filter
    import gthf_pkg::*;
#(
    parameter int MAX_WIDTH  = 1024,
    parameter int MAX_HEIGHT = 4096,
    parameter int MAX_HALF   = 15
)
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              wr_en,
    input  logic [IDX_W-1:0]  wr_index,
    input  logic [DATA_W-1:0] wr_data,
    input  logic              push,
    output logic              full,
    input  logic              command,
    input  logic [PIX_W-1:0]  pixel,
    output logic              empty,
    input  logic              pop,
    output logic [PIX_W-1:0]  tophat,
    output logic              last
);

    logic q_push, q_full, q_pop, q_empty;
    cmd_t q_in, q_out;

    assign full = q_full;

    gthf_front #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .MAX_HALF   (MAX_HALF)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .push     (push),
        .command  (command),
        .pixel    (pixel),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_cmd    (q_in)
    );

    gthf_cmdq u_cmdq (
        .clk   (clk),
        .rst_n (rst_n),
        .push  (q_push),
        .din   (q_in),
        .full  (q_full),
        .pop   (q_pop),
        .dout  (q_out),
        .empty (q_empty)
    );

    gthf_back #(
        .MAX_WIDTH (MAX_WIDTH),
        .MAX_HALF  (MAX_HALF)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .q_empty (q_empty),
        .q_pop   (q_pop),
        .q_cmd   (q_out),
        .pop     (pop),
        .empty   (empty),
        .tophat  (tophat),
        .last    (last)
    );

endmodule
